// ===== design/scsf_pkg.sv =====
package scsf_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned CfgIndexWidth = 1;

    typedef logic [WordWidth-1:0] word_t;

    typedef enum logic [2:0] {
        OP_INIT       = 3'd0,
        OP_SET_BACKUP = 3'd1,
        OP_STAGE      = 3'd2,
        OP_ACK        = 3'd3,
        OP_PUBLISHED  = 3'd4,
        OP_ABORT      = 3'd5,
        OP_HOLD       = 3'd6,
        OP_SAW        = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STAGED = 3'b010,
        PH_ACKED  = 3'b100
    } phase_t;

    // external phase codes
    localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_CODE_STAGED = 2'd1;
    localparam logic [1:0] PHASE_CODE_ACKED  = 2'd2;

    localparam logic [CfgIndexWidth-1:0] REG_EPOCH_TERM = 1'd0;
    localparam logic [CfgIndexWidth-1:0] REG_START_SEQ  = 1'd1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic       status;
        word_t      stage_no;
        word_t      pub_no;
        logic [1:0] phase;
        logic       unsynced;
        logic       owed;
        word_t      owed_term;
        word_t      owed_seq;
        word_t      staged_total;
        word_t      acked_total;
        word_t      published_total;
        word_t      unsynced_total;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE:   code = PHASE_CODE_IDLE;
            PH_STAGED: code = PHASE_CODE_STAGED;
            PH_ACKED:  code = PHASE_CODE_ACKED;
            default:   code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/staged_commit_sync_fsm.sv =====
// staged_commit_sync_fsm: primary/backup staging controller
//
// input channel (in_valid/in_ready) carries one event word: op, term_in,
// seq_in and backup_flag. each accepted event yields exactly one result word
// on the output channel (out_valid/out_ready): status, staged and published
// sequences, phase, hold state and the four wrapping event counters.
// the event is decoded against the controller state in the cycle it is accepted,
// and the state and the result register update together at that edge.
// throughput is one event per cycle while the receiver keeps up; the only limit is
// the single result register.
// when the receiver stalls the result register holds its word and in_ready
// drops until the word is taken; in the cycle it is taken a new event may be
// accepted at the same time.
// configuration: cfg_we with cfg_index (0 epoch_term, 1 start_seq) and
// cfg_data writes a register at that edge; epoch_term is compared live by ack
// events, start_seq is loaded by init.
// reset (rst_n low, asynchronous) empties the result register and returns the
// controller to idle with next sequence 1 and all counters and registers 0.
module staged_commit_sync_fsm
    import scsf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [WordWidth-1:0]     cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               op,
    input  logic [WordWidth-1:0]     term_in,
    input  logic [WordWidth-1:0]     seq_in,
    input  logic                     backup_flag,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     status,
    output logic [WordWidth-1:0]     staged_seq_out,
    output logic [WordWidth-1:0]     published_seq_out,
    output logic [1:0]               phase,
    output logic                     unsynced,
    output logic                     owed,
    output logic [WordWidth-1:0]     owed_term,
    output logic [WordWidth-1:0]     owed_seq,
    output logic [WordWidth-1:0]     staged_total,
    output logic [WordWidth-1:0]     acked_total,
    output logic [WordWidth-1:0]     published_total,
    output logic [WordWidth-1:0]     unsynced_total
);

    word_t   epoch_term_reg;
    word_t   start_seq_reg;

    phase_t  phase_reg, phase_next;
    logic    backup_reg, backup_next;
    word_t   seq_ctr_reg, seq_ctr_next;
    word_t   stage_no_reg, stage_no_next;
    word_t   pub_no_reg, pub_no_next;
    logic    unsynced_reg, unsynced_next;
    word_t   staged_count_reg, staged_count_next;
    word_t   acked_count_reg, acked_count_next;
    word_t   published_count_reg, published_count_next;
    word_t   unsynced_count_reg, unsynced_count_next;
    logic    owed_reg, owed_next;
    word_t   held_term_reg, held_term_next;
    word_t   held_seq_reg, held_seq_next;
    logic    reject;

    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic    in_fire;
    op_t     op_dec;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign op_dec   = op_t'(op);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_term_reg <= '0;
            start_seq_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EPOCH_TERM: epoch_term_reg <= cfg_data;
                REG_START_SEQ:  start_seq_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // event decode
    always_comb
    begin
        phase_next           = phase_reg;
        backup_next          = backup_reg;
        seq_ctr_next         = seq_ctr_reg;
        stage_no_next        = stage_no_reg;
        pub_no_next          = pub_no_reg;
        unsynced_next        = unsynced_reg;
        staged_count_next    = staged_count_reg;
        acked_count_next     = acked_count_reg;
        published_count_next = published_count_reg;
        unsynced_count_next  = unsynced_count_reg;
        owed_next            = owed_reg;
        held_term_next       = held_term_reg;
        held_seq_next        = held_seq_reg;
        reject               = STATUS_OK;

        unique case (op_dec)
            OP_INIT:
            begin
                phase_next           = PH_IDLE;
                backup_next          = 1'b0;
                stage_no_next        = '0;
                pub_no_next          = start_seq_reg;
                seq_ctr_next         = start_seq_reg + word_t'(1);
                unsynced_next        = 1'b0;
                staged_count_next    = '0;
                acked_count_next     = '0;
                published_count_next = '0;
                unsynced_count_next  = '0;
                owed_next            = 1'b0;
                held_term_next       = '0;
                held_seq_next        = '0;
            end
            OP_SET_BACKUP:
            begin
                backup_next = backup_flag;
            end
            OP_STAGE:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    reject = STATUS_REJECTED;
                end
                else
                begin
                    stage_no_next     = seq_ctr_reg;
                    seq_ctr_next      = seq_ctr_reg + word_t'(1);
                    staged_count_next = staged_count_reg + word_t'(1);
                    if (backup_reg)
                    begin
                        phase_next    = PH_STAGED;
                        unsynced_next = 1'b0;
                    end
                    else
                    begin
                        // no backup to wait for: publishable at once
                        phase_next          = PH_ACKED;
                        unsynced_next       = 1'b1;
                        unsynced_count_next = unsynced_count_reg + word_t'(1);
                    end
                end
            end
            OP_ACK:
            begin
                if (phase_reg != PH_STAGED || term_in != epoch_term_reg
                    || seq_in != stage_no_reg)
                begin
                    reject = STATUS_REJECTED;
                end
                else
                begin
                    phase_next       = PH_ACKED;
                    acked_count_next = acked_count_reg + word_t'(1);
                end
            end
            OP_PUBLISHED:
            begin
                if (phase_reg != PH_ACKED)
                begin
                    reject = STATUS_REJECTED;
                end
                else
                begin
                    pub_no_next          = stage_no_reg;
                    phase_next           = PH_IDLE;
                    unsynced_next        = 1'b0;
                    published_count_next = published_count_reg + word_t'(1);
                end
            end
            OP_ABORT:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    reject = STATUS_REJECTED;
                end
                else
                begin
                    phase_next    = PH_IDLE;
                    unsynced_next = 1'b0;
                end
            end
            OP_HOLD:
            begin
                owed_next      = 1'b1;
                held_term_next = term_in;
                held_seq_next  = seq_in;
            end
            OP_SAW:
            begin
                // release once the seen term/seq epoch reaches the held one
                if (owed_reg && (term_in > held_term_reg
                    || (term_in == held_term_reg && seq_in >= held_seq_reg)))
                begin
                    owed_next = 1'b0;
                end
            end
            default:
            begin
                reject = STATUS_REJECTED;
            end
        endcase
    end

    always_comb
    begin
        result_next.status          = reject;
        result_next.stage_no        = stage_no_next;
        result_next.pub_no          = pub_no_next;
        result_next.phase           = phase_code(phase_next);
        result_next.unsynced        = unsynced_next;
        result_next.owed            = owed_next;
        result_next.owed_term       = owed_next ? held_term_next : '0;
        result_next.owed_seq        = owed_next ? held_seq_next : '0;
        result_next.staged_total    = staged_count_next;
        result_next.acked_total     = acked_count_next;
        result_next.published_total = published_count_next;
        result_next.unsynced_total  = unsynced_count_next;
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            backup_reg          <= 1'b0;
            seq_ctr_reg         <= word_t'(1);
            stage_no_reg        <= '0;
            pub_no_reg          <= '0;
            unsynced_reg        <= 1'b0;
            staged_count_reg    <= '0;
            acked_count_reg     <= '0;
            published_count_reg <= '0;
            unsynced_count_reg  <= '0;
            owed_reg            <= 1'b0;
            held_term_reg       <= '0;
            held_seq_reg        <= '0;
        end
        else if (in_fire)
        begin
            phase_reg           <= phase_next;
            backup_reg          <= backup_next;
            seq_ctr_reg         <= seq_ctr_next;
            stage_no_reg        <= stage_no_next;
            pub_no_reg          <= pub_no_next;
            unsynced_reg        <= unsynced_next;
            staged_count_reg    <= staged_count_next;
            acked_count_reg     <= acked_count_next;
            published_count_reg <= published_count_next;
            unsynced_count_reg  <= unsynced_count_next;
            owed_reg            <= owed_next;
            held_term_reg       <= held_term_next;
            held_seq_reg        <= held_seq_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = result_reg.status;
    assign staged_seq_out    = result_reg.stage_no;
    assign published_seq_out = result_reg.pub_no;
    assign phase             = result_reg.phase;
    assign unsynced          = result_reg.unsynced;
    assign owed              = result_reg.owed;
    assign owed_term         = result_reg.owed_term;
    assign owed_seq          = result_reg.owed_seq;
    assign staged_total      = result_reg.staged_total;
    assign acked_total       = result_reg.acked_total;
    assign published_total   = result_reg.published_total;
    assign unsynced_total    = result_reg.unsynced_total;

    // an unsynced change is always publishable
    a_unsynced_acked: assert property (@(posedge clk) disable iff (!rst_n)
        unsynced_reg |-> phase_reg == PH_ACKED)
        else $error("unsynced flag set outside the acked phase");

    // sequence numbers move only on init or an accepted stage
    a_seq_no_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op_dec != OP_INIT && !(op_dec == OP_STAGE && phase_reg == PH_IDLE))
        |=> $stable(seq_ctr_reg))
        else $error("next sequence changed without a stage or init");

    a_stage_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op_dec == OP_STAGE && phase_reg == PH_IDLE)
        |=> staged_count_reg == $past(staged_count_reg) + word_t'(1))
        else $error("accepted stage not counted");

    a_owed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_reg.owed)
        |-> (result_reg.owed_term == '0 && result_reg.owed_seq == '0))
        else $error("hold fields reported without a pending hold");

    // a stalled result is never overwritten
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(result_reg)))
        else $error("stalled result lost");

endmodule

// ===== tb/sv/staged_commit_sync_fsm_test.sv =====
module staged_commit_sync_fsm_test
    import scsf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam word_t ALL_ONES = '1;

    // predicted controller state and the queue of result words still owed by the block
    class staging_tracker;
        word_t      epoch_term;
        word_t      start_seq;
        logic [1:0] cur_phase;
        logic       backup_present;
        word_t      seq_ctr;
        word_t      stage_no;
        word_t      pub_no;
        logic       unsynced_flag;
        word_t      staged_count;
        word_t      acked_count;
        word_t      published_count;
        word_t      unsynced_count;
        logic       owed_flag;
        word_t      held_term;
        word_t      held_seq;
        result_t    expected_reports[$];
        int unsigned mismatches;

        function new();
            epoch_term = '0;
            start_seq  = '0;
            mismatches = 0;
            clear_controller();
        endfunction

        function void clear_controller();
            cur_phase       = PHASE_CODE_IDLE;
            backup_present  = 1'b0;
            seq_ctr         = 32'd1;
            stage_no        = '0;
            pub_no          = '0;
            unsynced_flag   = 1'b0;
            staged_count    = '0;
            acked_count     = '0;
            published_count = '0;
            unsynced_count  = '0;
            owed_flag       = 1'b0;
            held_term       = '0;
            held_seq        = '0;
        endfunction

        function void write_reg(logic [CfgIndexWidth-1:0] idx, word_t data);
            if (idx == REG_EPOCH_TERM)
                epoch_term = data;
            else if (idx == REG_START_SEQ)
                start_seq = data;
        endfunction

        function void note_event(op_t o, word_t t, word_t q, logic bf);
            result_t want;
            logic    rej;
            rej = STATUS_OK;
            case (o)
                OP_INIT:
                begin
                    clear_controller();
                    pub_no  = start_seq;
                    seq_ctr = start_seq + 32'd1;
                end
                OP_SET_BACKUP: backup_present = bf;
                OP_STAGE:
                begin
                    if (cur_phase != PHASE_CODE_IDLE)
                        rej = STATUS_REJECTED;
                    else
                    begin
                        stage_no     = seq_ctr;
                        seq_ctr      = seq_ctr + 32'd1;
                        staged_count = staged_count + 32'd1;
                        if (backup_present)
                        begin
                            cur_phase     = PHASE_CODE_STAGED;
                            unsynced_flag = 1'b0;
                        end
                        else
                        begin
                            // no backup to wait for: straight to publishable
                            cur_phase      = PHASE_CODE_ACKED;
                            unsynced_flag  = 1'b1;
                            unsynced_count = unsynced_count + 32'd1;
                        end
                    end
                end
                OP_ACK:
                begin
                    if (cur_phase != PHASE_CODE_STAGED || t != epoch_term || q != stage_no)
                        rej = STATUS_REJECTED;
                    else
                    begin
                        cur_phase   = PHASE_CODE_ACKED;
                        acked_count = acked_count + 32'd1;
                    end
                end
                OP_PUBLISHED:
                begin
                    if (cur_phase != PHASE_CODE_ACKED)
                        rej = STATUS_REJECTED;
                    else
                    begin
                        pub_no          = stage_no;
                        cur_phase       = PHASE_CODE_IDLE;
                        unsynced_flag   = 1'b0;
                        published_count = published_count + 32'd1;
                    end
                end
                OP_ABORT:
                begin
                    if (cur_phase == PHASE_CODE_IDLE)
                        rej = STATUS_REJECTED;
                    else
                    begin
                        cur_phase     = PHASE_CODE_IDLE;
                        unsynced_flag = 1'b0;
                    end
                end
                OP_HOLD:
                begin
                    owed_flag = 1'b1;
                    held_term = t;
                    held_seq  = q;
                end
                default:
                begin
                    // saw: release once the epoch reaches the held one
                    if (owed_flag && (t > held_term || (t == held_term && q >= held_seq)))
                        owed_flag = 1'b0;
                end
            endcase
            want.status          = rej;
            want.stage_no        = stage_no;
            want.pub_no          = pub_no;
            want.phase           = cur_phase;
            want.unsynced        = unsynced_flag;
            want.owed            = owed_flag;
            want.owed_term       = owed_flag ? held_term : '0;
            want.owed_seq        = owed_flag ? held_seq : '0;
            want.staged_total    = staged_count;
            want.acked_total     = acked_count;
            want.published_total = published_count;
            want.unsynced_total  = unsynced_count;
            expected_reports.push_back(want);
        endfunction

        function void compare_field(string name, word_t want, word_t seen);
            if (want !== seen)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
            end
        endfunction

        function void check_report(result_t seen);
            result_t want;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result word with nothing outstanding: %h", $time, seen);
                return;
            end
            want = expected_reports.pop_front();
            compare_field("status", word_t'(want.status), word_t'(seen.status));
            compare_field("staged_seq_out", want.stage_no, seen.stage_no);
            compare_field("published_seq_out", want.pub_no, seen.pub_no);
            compare_field("phase", word_t'(want.phase), word_t'(seen.phase));
            compare_field("unsynced", word_t'(want.unsynced), word_t'(seen.unsynced));
            compare_field("owed", word_t'(want.owed), word_t'(seen.owed));
            compare_field("owed_term", want.owed_term, seen.owed_term);
            compare_field("owed_seq", want.owed_seq, seen.owed_seq);
            compare_field("staged_total", want.staged_total, seen.staged_total);
            compare_field("acked_total", want.acked_total, seen.acked_total);
            compare_field("published_total", want.published_total, seen.published_total);
            compare_field("unsynced_total", want.unsynced_total, seen.unsynced_total);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    word_t                    cfg_data;

    logic  in_valid;
    logic  in_ready;
    op_t   op_drv;
    word_t term_drv;
    word_t seq_drv;
    logic  flag_drv;

    logic       out_valid;
    logic       out_ready;
    logic       status;
    word_t      staged_seq_out;
    word_t      published_seq_out;
    logic [1:0] phase;
    logic       unsynced;
    logic       owed;
    word_t      owed_term;
    word_t      owed_seq;
    word_t      staged_total;
    word_t      acked_total;
    word_t      published_total;
    word_t      unsynced_total;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    staging_tracker sb = new();

    staged_commit_sync_fsm dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .op                (op_drv),
        .term_in           (term_drv),
        .seq_in            (seq_drv),
        .backup_flag       (flag_drv),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .staged_seq_out    (staged_seq_out),
        .published_seq_out (published_seq_out),
        .phase             (phase),
        .unsynced          (unsynced),
        .owed              (owed),
        .owed_term         (owed_term),
        .owed_seq          (owed_seq),
        .staged_total      (staged_total),
        .acked_total       (acked_total),
        .published_total   (published_total),
        .unsynced_total    (unsynced_total)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_report({status, staged_seq_out, published_seq_out, phase, unsynced, owed,
                             owed_term, owed_seq, staged_total, acked_total, published_total,
                             unsynced_total});
    end

    task automatic send_event(input op_t o, input word_t t, input word_t q, input logic bf);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op_drv   <= o;
        term_drv <= t;
        seq_drv  <= q;
        flag_drv <= bf;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_event(o, t, q, bf);
    endtask

    // both registers back to back, enable held high across the pair
    task automatic write_settings(input word_t epoch, input word_t first_seq);
        cfg_we    <= 1'b1;
        cfg_index <= REG_EPOCH_TERM;
        cfg_data  <= epoch;
        @(posedge clk);
        sb.write_reg(REG_EPOCH_TERM, epoch);
        cfg_index <= REG_START_SEQ;
        cfg_data  <= first_seq;
        @(posedge clk);
        sb.write_reg(REG_START_SEQ, first_seq);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t nudge(input word_t x);
        case ($urandom_range(0, 3))
            0: return x;
            1: return x + 32'd1;
            2: return x - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // mostly well-formed stage/ack/publish runs, with some noise mixed in
    task automatic random_event(output op_t o, output word_t t, output word_t q,
                                output logic bf);
        int unsigned r;
        r  = $urandom_range(0, 99);
        t  = $urandom;
        q  = $urandom;
        bf = 1'($urandom_range(0, 1));
        o  = OP_STAGE;
        if (r < 10)
            o = op_t'($urandom_range(0, 7));
        else if (r < 12)
            o = OP_INIT;
        else if (r < 19)
        begin
            o  = OP_SET_BACKUP;
            bf = ($urandom_range(0, 3) != 0);
        end
        else if (r < 24)
            o = OP_HOLD;
        else if (r < 30)
        begin
            o = OP_SAW;
            t = nudge(sb.held_term);
            q = nudge(sb.held_seq);
        end
        else
        begin
            case (sb.cur_phase)
                PHASE_CODE_IDLE: o = (r < 90) ? OP_STAGE : op_t'($urandom_range(3, 5));
                PHASE_CODE_STAGED:
                begin
                    if (r < 85)
                    begin
                        o = OP_ACK;
                        t = (r < 75) ? sb.epoch_term : nudge(sb.epoch_term);
                        q = (r < 75) ? sb.stage_no : nudge(sb.stage_no);
                    end
                    else
                        o = (r < 92) ? OP_ABORT : OP_STAGE;
                end
                default:
                begin
                    if (r < 85)
                        o = OP_PUBLISHED;
                    else
                        o = (r < 92) ? OP_ABORT : OP_ACK;
                end
            endcase
        end
    endtask

    task automatic run_directed();
        send_event(OP_INIT, $urandom, $urandom, 1'b1);         // start_seq all ones, next wraps to 0
        send_event(OP_STAGE, '0, '0, 1'b0);                    // no backup: straight to acked
        send_event(OP_STAGE, '0, '0, 1'b0);                    // stage while busy
        send_event(OP_ACK, ALL_ONES, '0, 1'b0);                // ack outside staged
        send_event(OP_PUBLISHED, '0, '0, 1'b0);
        send_event(OP_PUBLISHED, '0, '0, 1'b0);                // publish in idle
        send_event(OP_ABORT, '0, '0, 1'b0);                    // abort in idle
        send_event(OP_SET_BACKUP, '0, '0, 1'b1);
        send_event(OP_STAGE, ALL_ONES, ALL_ONES, 1'b0);
        send_event(OP_ACK, '0, 32'd1, 1'b0);                   // wrong term
        send_event(OP_ACK, ALL_ONES, 32'd2, 1'b0);             // wrong sequence
        send_event(OP_ACK, ALL_ONES, 32'd1, 1'b0);
        send_event(OP_ACK, ALL_ONES, 32'd1, 1'b0);             // second ack once acked
        send_event(OP_ABORT, '0, '0, 1'b0);                    // abort from acked
        send_event(OP_STAGE, '0, '0, 1'b0);
        send_event(OP_SET_BACKUP, ALL_ONES, ALL_ONES, 1'b0);   // backup lost mid-flight
        send_event(OP_ABORT, '0, '0, 1'b0);                    // abort from staged
        send_event(OP_SAW, '0, '0, 1'b1);                      // saw with nothing held
        send_event(OP_HOLD, ALL_ONES, ALL_ONES, 1'b0);
        send_event(OP_SAW, ALL_ONES, ALL_ONES - 32'd1, 1'b0);
        send_event(OP_SAW, '0, ALL_ONES, 1'b0);
        send_event(OP_SAW, ALL_ONES, ALL_ONES, 1'b0);          // equal epoch releases
        send_event(OP_HOLD, 32'd5, ALL_ONES, 1'b1);
        send_event(OP_SAW, 32'd6, '0, 1'b0);                   // later term releases
        send_event(OP_INIT, ALL_ONES, ALL_ONES, 1'b1);
    endtask

    initial
    begin
        op_t   o;
        word_t t;
        word_t q;
        logic  bf;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_EPOCH_TERM;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        op_drv    <= OP_INIT;
        term_drv  <= '0;
        seq_drv   <= '0;
        flag_drv  <= 1'b0;
        out_ready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings(ALL_ONES, ALL_ONES);
        run_directed();
        drain_reports();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    write_settings('0, '0);
                end
                1:
                begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 0;
                    write_settings(ALL_ONES, ALL_ONES - 32'd1);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 66;
                    write_settings($urandom, $urandom);
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                    write_settings($urandom, $urandom);
                end
            endcase
            send_event(OP_INIT, $urandom, $urandom, 1'($urandom_range(0, 1)));
            repeat (245)
            begin
                random_event(o, t, q, bf);
                send_event(o, t, q, bf);
            end
            drain_reports();
        end

        repeat (5) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
design/scsf_pkg.sv
design/staged_commit_sync_fsm.sv
tb/sv/staged_commit_sync_fsm_test.sv
